// ===== design/entity_acquire_lock_table_defines.svh =====
// assertion macros for the entity acquire/lock table
`ifndef ENTITY_ACQUIRE_LOCK_TABLE_DEFINES_SVH
`define ENTITY_ACQUIRE_LOCK_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define EALT_ASSERT(lbl, clk, rst, prp, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prp) else $error(msg);
// property checked on every edge, reset included
`define EALT_ASSERT_ALWAYS(lbl, clk, prp, msg) \
   lbl: assert property (@(posedge clk) prp) else $error(msg);
`else
`define EALT_ASSERT(lbl, clk, rst, prp, msg)
`define EALT_ASSERT_ALWAYS(lbl, clk, prp, msg)
`endif

`endif

// ===== design/ealt_pkg.sv =====
package ealt_pkg;

   parameter int MAX_ENTRIES_DEF = 64;

   localparam int ID_W        = 64;
   localparam int CFG_W       = 16;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 88;

   typedef enum logic [MODE_W-1:0] {
      MODE_ACQUIRE = 3'd0,
      MODE_RELEASE = 3'd1,
      MODE_LOCK    = 3'd2,
      MODE_QUERY   = 3'd3,
      MODE_SET_CFG = 3'd4,
      MODE_GET_CFG = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK              = 3'd0,
      ST_ACQUIRED        = 3'd1,
      ST_LOCKED          = 3'd2,
      ST_NO_ENTITY       = 3'd3,
      ST_BAD_ARGS        = 3'd4,
      ST_RELEASE_REFUSED = 3'd5
   } status_type;

   // one table row as stored in the ram
   typedef struct packed {
      logic            locked;
      logic            acquired;
      logic [ID_W-1:0] owner;
      logic [ID_W-1:0] id;
   } entry_type;

endpackage

// ===== design/ealt_ram.sv =====
module ealt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/entity_acquire_lock_table.sv =====
// channel | dir | handshake            | tdata fields, lowest bit first
// req     | in  | req_tvalid/tready    | mode, entity_id, controller_id, config_value
// rsp     | out | rsp_tvalid/tready    | status, is_acquired, is_locked, owner, config_out
//
// the id search reads one table row per cycle from the single ram read port and stops
// at a hit, then the decide state updates the row.
// the block takes a new item only when idle; a finished result waits in the
// output register, and the decide cycle stalls while that register is full.
// synchronous reset empties the table (fill count) and clears the config index.
`include "entity_acquire_lock_table_defines.svh"

module entity_acquire_lock_table #(
   parameter int MAX_ENTRIES = ealt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode, entity_id, controller_id, config_value, zero fill
   input  logic [ealt_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, is_acquired, is_locked, owner, config_out, zero fill
   output logic [ealt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import ealt_pkg::*;

   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              pend_ff, pend_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              ent_acq_ff, ent_acq_in;
   logic              ent_lock_ff, ent_lock_in;
   logic [ID_W-1:0]   ent_owner_ff, ent_owner_in;
   logic [MODE_W-1:0] cmd_mode_ff, cmd_mode_in;
   logic [ID_W-1:0]   cmd_eid_ff, cmd_eid_in;
   logic [ID_W-1:0]   cmd_cid_ff, cmd_cid_in;
   logic [CFG_W-1:0]  cmd_cval_ff, cmd_cval_in;
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [CFG_W-1:0]  config_ff, config_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic              accept;
   logic              issue;
   logic              fire;
   logic              full;
   logic [ID_W-1:0]   cmp_a, cmp_b;
   logic              cmp_eq;
   entry_type         rd_word;
   entry_type         wr_word;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   status_type        status;
   logic              new_acq, new_lock;
   logic [ID_W-1:0]   new_owner;
   logic              append;

   ealt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(wr_word),
      .re   (issue),
      .raddr(addr_ff[AW-1:0]),
      .rdata(rd_word)
   );

   assign accept = req_tvalid && req_tready;
   assign issue  = (state_ff == S_SCAN) && (addr_ff != entry_count_ff);
   assign fire   = (state_ff == S_DECIDE) && (!rsp_tvalid_ff || rsp_tready);
   assign full   = (entry_count_ff == CNT_W'(MAX_ENTRIES));

   // one 64-bit comparator: ids while searching, owner vs controller when deciding
   always_comb begin
      if (state_ff == S_SCAN) begin
         cmp_a = rd_word.id;
         cmp_b = cmd_eid_ff;
      end else begin
         cmp_a = ent_owner_ff;
         cmp_b = cmd_cid_ff;
      end
   end
   assign cmp_eq = (cmp_a == cmp_b);

   // command decision
   always_comb begin
      status    = ST_OK;
      new_acq   = ent_acq_ff;
      new_lock  = ent_lock_ff;
      new_owner = ent_owner_ff;
      append    = 1'b0;
      ram_we    = 1'b0;
      config_in = config_ff;
      unique case (cmd_mode_ff)
         MODE_ACQUIRE: begin
            if (!hit_ff) begin
               if (full) begin
                  status = ST_ACQUIRED;
               end else begin
                  append    = 1'b1;
                  ram_we    = fire;
                  new_acq   = 1'b1;
                  new_lock  = 1'b0;
                  new_owner = cmd_cid_ff;
               end
            end else if (ent_acq_ff && !cmp_eq) begin
               status = ST_ACQUIRED;
            end else begin
               ram_we    = fire;
               new_acq   = 1'b1;
               new_owner = cmd_cid_ff;
            end
         end
         MODE_RELEASE: begin
            if (!hit_ff || !ent_acq_ff || !cmp_eq) begin
               status = ST_RELEASE_REFUSED;
            end else begin
               ram_we    = fire;
               new_acq   = 1'b0;
               new_lock  = 1'b0;
               new_owner = '0;
            end
         end
         MODE_LOCK: begin
            if (!hit_ff) begin
               status = ST_NO_ENTITY;
            end else if (ent_acq_ff && cmp_eq) begin
               ram_we   = fire;
               new_lock = 1'b1;
            end else begin
               status = ST_LOCKED;
            end
         end
         MODE_QUERY, MODE_GET_CFG: begin
            status = ST_OK;
         end
         MODE_SET_CFG: begin
            if (entry_count_ff != '0) begin
               if (fire) begin
                  config_in = cmd_cval_ff;
               end
            end else begin
               status = ST_BAD_ARGS;
            end
         end
         default: begin
            status = ST_BAD_ARGS;
         end
      endcase
   end

   assign ram_waddr        = append ? entry_count_ff[AW-1:0] : slot_ff;
   assign wr_word.locked   = new_lock;
   assign wr_word.acquired = new_acq;
   assign wr_word.owner    = new_owner;
   assign wr_word.id       = cmd_eid_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      cmp_idx_in     = cmp_idx_ff;
      pend_in        = pend_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      ent_acq_in     = ent_acq_ff;
      ent_lock_in    = ent_lock_ff;
      ent_owner_in   = ent_owner_ff;
      cmd_mode_in    = cmd_mode_ff;
      cmd_eid_in     = cmd_eid_ff;
      cmd_cid_in     = cmd_cid_ff;
      cmd_cval_in    = cmd_cval_ff;
      entry_count_in = entry_count_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;

      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_mode_in = req_tdata[2:0];
               cmd_eid_in  = req_tdata[66:3];
               cmd_cid_in  = req_tdata[130:67];
               cmd_cval_in = req_tdata[146:131];
               addr_in     = '0;
               pend_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // row read at addr_ff comes back next cycle, tagged by cmp_idx_ff
            pend_in    = issue;
            cmp_idx_in = addr_ff;
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (pend_ff && cmp_eq) begin
               hit_in       = 1'b1;
               slot_in      = cmp_idx_ff[AW-1:0];
               ent_acq_in   = rd_word.acquired;
               ent_lock_in  = rd_word.locked;
               ent_owner_in = rd_word.owner;
               state_in     = S_DECIDE;
            end else if (!issue) begin
               hit_in       = 1'b0;
               ent_acq_in   = 1'b0;
               ent_lock_in  = 1'b0;
               ent_owner_in = '0;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (fire) begin
               if (append) begin
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {3'b000, config_in, new_owner, new_lock, new_acq, status};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pend_ff        <= 1'b0;
         entry_count_ff <= '0;
         config_ff      <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         entry_count_ff <= entry_count_in;
         config_ff      <= config_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      ent_acq_ff   <= ent_acq_in;
      ent_lock_ff  <= ent_lock_in;
      ent_owner_ff <= ent_owner_in;
      cmd_mode_ff  <= cmd_mode_in;
      cmd_eid_ff   <= cmd_eid_in;
      cmd_cid_ff   <= cmd_cid_in;
      cmd_cval_ff  <= cmd_cval_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `EALT_ASSERT(a_count_bound, clock, reset, entry_count_ff <= CNT_W'(MAX_ENTRIES), "table fill count beyond depth")
   `EALT_ASSERT(a_hit_in_range, clock, reset, (state_ff == S_SCAN && pend_ff) |-> (cmp_idx_ff < entry_count_ff), "search compared a row beyond the fill count")
   `EALT_ASSERT(a_cfg_only_on_set, clock, reset, (state_ff == S_DECIDE && cmd_mode_ff != MODE_SET_CFG) |=> $stable(config_ff), "config index changed by a command other than set")
   `EALT_ASSERT(a_no_write_while_search, clock, reset, (state_ff != S_DECIDE) |-> !ram_we, "table written outside the decide cycle")

endmodule
